// ===== sv/sbm_pkg.sv =====
package sbm_pkg;

	localparam int STACK_DEPTH    = 1024;
	localparam int MAX_ARGS       = 4;
	localparam int PROG_ADDR_BITS = 16;
	localparam int ADDR_W         = $clog2(STACK_DEPTH);
	localparam int SP_W           = ADDR_W + 1;
	localparam int WIDE_W         = 34;
	localparam int ARG_IDX_W      = 2;
	localparam int PADDR_W        = 5;

	localparam logic [31:0] FB_RESET = 32'hFFFF_FC19;

	localparam logic [7:0] OP_CSTI   = 8'd0;
	localparam logic [7:0] OP_ADD    = 8'd1;
	localparam logic [7:0] OP_SUB    = 8'd2;
	localparam logic [7:0] OP_MUL    = 8'd3;
	localparam logic [7:0] OP_DIV    = 8'd4;
	localparam logic [7:0] OP_MOD    = 8'd5;
	localparam logic [7:0] OP_EQ     = 8'd6;
	localparam logic [7:0] OP_LT     = 8'd7;
	localparam logic [7:0] OP_NOT    = 8'd8;
	localparam logic [7:0] OP_DUP    = 8'd9;
	localparam logic [7:0] OP_SWAP   = 8'd10;
	localparam logic [7:0] OP_LDI    = 8'd11;
	localparam logic [7:0] OP_STI    = 8'd12;
	localparam logic [7:0] OP_GETBP  = 8'd13;
	localparam logic [7:0] OP_GETSP  = 8'd14;
	localparam logic [7:0] OP_INCSP  = 8'd15;
	localparam logic [7:0] OP_GOTO   = 8'd16;
	localparam logic [7:0] OP_IFZERO = 8'd17;
	localparam logic [7:0] OP_IFNZRO = 8'd18;
	localparam logic [7:0] OP_CALL   = 8'd19;
	localparam logic [7:0] OP_TCALL  = 8'd20;
	localparam logic [7:0] OP_RET    = 8'd21;
	localparam logic [7:0] OP_PRINTI = 8'd22;
	localparam logic [7:0] OP_PRINTC = 8'd23;
	localparam logic [7:0] OP_LDARGS = 8'd24;
	localparam logic [7:0] OP_STOP   = 8'd25;

	localparam logic [2:0] ERR_NONE    = 3'd0;
	localparam logic [2:0] ERR_ILLEGAL = 3'd1;
	localparam logic [2:0] ERR_STACK   = 3'd2;
	localparam logic [2:0] ERR_ADDR    = 3'd3;
	localparam logic [2:0] ERR_DIV0    = 3'd4;

	localparam logic [2:0] REG_ARG_COUNT = 3'd0;
	localparam logic [2:0] REG_ARG_0     = 3'd1;
	localparam logic [2:0] REG_ARG_1     = 3'd2;
	localparam logic [2:0] REG_ARG_2     = 3'd3;
	localparam logic [2:0] REG_ARG_3     = 3'd4;

	typedef struct packed {
		logic [7:0]         opcode;
		logic signed [31:0] operand_a;
		logic signed [31:0] operand_b;
		logic signed [31:0] operand_c;
	} instr_t;

	typedef struct packed {
		logic [15:0]        next_pc;
		logic               print_valid;
		logic               print_kind;
		logic signed [31:0] print_value;
		logic               halted;
		logic [2:0]         error_code;
	} result_t;

	typedef struct packed {
		instr_t instr;
		logic   illegal;
	} dec_t;

	typedef struct packed {
		logic        start;
		logic [31:0] dividend;
		logic [31:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] quo;
		logic [31:0] rem;
	} div_rsp_t;

endpackage

// ===== sv/sbm_front.sv =====
module sbm_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	output logic            full,
	input  sbm_pkg::instr_t instr,
	output logic            deq_valid,
	input  logic            deq,
	output sbm_pkg::dec_t   deq_item
);

	sbm_pkg::dec_t ent_q [2];
	logic          wr_q;
	logic          rd_q;
	logic [1:0]    cnt_q;
	logic          do_push;
	logic          do_pop;
	sbm_pkg::dec_t dec;

	always_comb begin
		dec.instr   = instr;
		dec.illegal = (instr.opcode > sbm_pkg::OP_STOP);
	end

	assign full      = (cnt_q == 2'd2);
	assign deq_valid = (cnt_q != 2'd0);
	assign deq_item  = ent_q[rd_q];
	assign do_push   = push && !full;
	assign do_pop    = deq && deq_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) begin
				wr_q <= !wr_q;
			end
			if (do_pop) begin
				rd_q <= !rd_q;
			end
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_q] <= dec;
		end
	end

endmodule

// ===== sv/sbm_div.sv =====
module sbm_div (
	input  logic              clk,
	input  logic              arst_n,
	input  sbm_pkg::div_req_t req,
	output sbm_pkg::div_rsp_t rsp
);

	logic        busy_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic [31:0] rem_q;
	logic [31:0] quo_q;
	logic [31:0] dsr_q;
	logic        negq_q;
	logic        negr_q;
	logic [32:0] shifted;
	logic [32:0] diff;

	assign shifted = {rem_q, quo_q[31]};
	assign diff    = shifted - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
			end else if (busy_q && cnt_q == 5'd31) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			cnt_q  <= 5'd0;
			rem_q  <= 32'd0;
			quo_q  <= req.dividend[31] ? -req.dividend : req.dividend;
			dsr_q  <= req.divisor[31] ? -req.divisor : req.divisor;
			negq_q <= req.dividend[31] ^ req.divisor[31];
			negr_q <= req.dividend[31];
		end else if (busy_q) begin
			cnt_q <= cnt_q + 5'd1;
			if (!diff[32]) begin
				rem_q <= diff[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= shifted[31:0];
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	always_comb begin
		rsp.done = done_q;
		rsp.quo  = negq_q ? -quo_q : quo_q;
		rsp.rem  = negr_q ? -rem_q : rem_q;
	end

endmodule

// ===== sv/sbm_back.sv =====
module sbm_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	input  sbm_pkg::dec_t      item,
	output logic               item_pop,
	input  logic               room,
	input  logic [2:0]         arg_count,
	input  logic [31:0]        arg_val [sbm_pkg::MAX_ARGS],
	output logic               res_push,
	output sbm_pkg::result_t   res_data,
	output sbm_pkg::div_req_t  div_req,
	input  sbm_pkg::div_rsp_t  div_rsp
);

	localparam int AW = sbm_pkg::ADDR_W;
	localparam int SW = sbm_pkg::SP_W;
	localparam int WW = sbm_pkg::WIDE_W;

	localparam logic [4:0] ST_IDLE    = 5'd0;
	localparam logic [4:0] ST_CHECK   = 5'd1;
	localparam logic [4:0] ST_RDY     = 5'd2;
	localparam logic [4:0] ST_RDX     = 5'd3;
	localparam logic [4:0] ST_DIV     = 5'd4;
	localparam logic [4:0] ST_SWAP2   = 5'd5;
	localparam logic [4:0] ST_STI2    = 5'd6;
	localparam logic [4:0] ST_LDI     = 5'd7;
	localparam logic [4:0] ST_RET1    = 5'd8;
	localparam logic [4:0] ST_RET2    = 5'd9;
	localparam logic [4:0] ST_CALL_RD = 5'd10;
	localparam logic [4:0] ST_CALL_WR = 5'd11;
	localparam logic [4:0] ST_CALL_RA = 5'd12;
	localparam logic [4:0] ST_CALL_FB = 5'd13;
	localparam logic [4:0] ST_TC_RD   = 5'd14;
	localparam logic [4:0] ST_TC_WR   = 5'd15;
	localparam logic [4:0] ST_ARGS    = 5'd16;

	localparam logic signed [WW-1:0] W_NEG1 = -1;
	localparam logic signed [WW-1:0] W_ZERO = 0;
	localparam logic signed [WW-1:0] W_ONE  = 1;
	localparam logic signed [WW-1:0] W_TWO  = 2;
	localparam logic signed [WW-1:0] W_DEP  = WW'(sbm_pkg::STACK_DEPTH);

	logic [31:0] stack_mem [sbm_pkg::STACK_DEPTH];
	logic [31:0] rdata_q;

	logic [4:0]           state_q, n_state;
	logic [7:0]           op_q;
	logic                 ill_q;
	logic signed [31:0]   a_q, b_q, c_q;
	logic [31:0]          x_q, n_x;
	logic [31:0]          y_q, n_y;
	logic signed [SW-1:0] sp_q, n_sp;
	logic [31:0]          fb_q, n_fb;
	logic [15:0]          pc_q, n_pc;
	logic                 halt_q, n_halt;
	logic [2:0]           err_q, n_err;
	logic [SW-1:0]        cnt_q, n_cnt;
	logic [SW-1:0]        num_q, n_num;
	logic [SW-1:0]        dis_q, n_dis;
	logic [AW-1:0]        t_q, n_t;

	logic                 we;
	logic [AW-1:0]        waddr;
	logic [31:0]          wdata;
	logic [AW-1:0]        raddr;
	logic                 done;
	logic                 pv, pk;
	logic [31:0]          pval;

	logic signed [WW-1:0] sp_w, a_w, b_w, inc_w, rd_w, x_w, num_w;
	logic signed [31:0]   rd_s, x_s, y_s;
	logic [2:0]           args_n;
	logic [31:0]          alu;

	always_comb begin
		rd_s   = rdata_q;
		x_s    = rdata_q;
		y_s    = y_q;
		sp_w   = WW'(sp_q);
		a_w    = WW'(a_q);
		b_w    = WW'(b_q);
		inc_w  = sp_w + a_w;
		rd_w   = WW'(rd_s);
		x_w    = WW'(x_s);
		num_w  = signed'(WW'(num_q));
		args_n = (arg_count > 3'(sbm_pkg::MAX_ARGS)) ? 3'(sbm_pkg::MAX_ARGS) : arg_count;
		case (op_q)
			sbm_pkg::OP_ADD: alu = rdata_q + y_q;
			sbm_pkg::OP_SUB: alu = rdata_q - y_q;
			sbm_pkg::OP_MUL: alu = rdata_q * y_q;
			sbm_pkg::OP_EQ:  alu = {31'd0, rdata_q == y_q};
			default:         alu = {31'd0, x_s < y_s};
		endcase
	end

	always_comb begin
		n_state  = state_q;
		n_x      = x_q;
		n_y      = y_q;
		n_sp     = sp_q;
		n_fb     = fb_q;
		n_pc     = pc_q;
		n_halt   = halt_q;
		n_err    = err_q;
		n_cnt    = cnt_q;
		n_num    = num_q;
		n_dis    = dis_q;
		n_t      = t_q;
		we       = 1'b0;
		waddr    = '0;
		wdata    = '0;
		raddr    = AW'(sp_q);
		done     = 1'b0;
		pv       = 1'b0;
		pk       = 1'b0;
		pval     = '0;
		item_pop = 1'b0;
		div_req.start    = 1'b0;
		div_req.dividend = rdata_q;
		div_req.divisor  = y_q;

		unique case (state_q)
			ST_IDLE: begin
				if (item_valid && room) begin
					item_pop = 1'b1;
					n_state  = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (halt_q) begin
					done = 1'b1;
				end else if (ill_q) begin
					done   = 1'b1;
					n_halt = 1'b1;
					n_err  = sbm_pkg::ERR_ILLEGAL;
				end else begin
					unique case (op_q) inside
						sbm_pkg::OP_CSTI, sbm_pkg::OP_GETBP, sbm_pkg::OP_GETSP: begin
							if (sp_w + W_ONE >= W_DEP) begin
								done   = 1'b1;
								n_halt = 1'b1;
								n_err  = sbm_pkg::ERR_STACK;
							end else begin
								we    = 1'b1;
								waddr = AW'(sp_q + SW'(1));
								if (op_q == sbm_pkg::OP_CSTI) begin
									wdata = a_q;
									n_pc  = pc_q + 16'd2;
								end else begin
									wdata = (op_q == sbm_pkg::OP_GETBP) ? fb_q : 32'(sp_q);
									n_pc  = pc_q + 16'd1;
								end
								n_sp = sp_q + SW'(1);
								done = 1'b1;
							end
						end
						sbm_pkg::OP_ADD, sbm_pkg::OP_SUB, sbm_pkg::OP_MUL, sbm_pkg::OP_DIV,
						sbm_pkg::OP_MOD, sbm_pkg::OP_EQ, sbm_pkg::OP_LT, sbm_pkg::OP_SWAP,
						sbm_pkg::OP_STI: begin
							if (sp_w < W_ONE) begin
								done   = 1'b1;
								n_halt = 1'b1;
								n_err  = sbm_pkg::ERR_STACK;
							end else begin
								n_state = ST_RDY;
							end
						end
						sbm_pkg::OP_NOT, sbm_pkg::OP_LDI, sbm_pkg::OP_IFZERO,
						sbm_pkg::OP_IFNZRO, sbm_pkg::OP_PRINTI, sbm_pkg::OP_PRINTC: begin
							if (sp_w < W_ZERO) begin
								done   = 1'b1;
								n_halt = 1'b1;
								n_err  = sbm_pkg::ERR_STACK;
							end else begin
								n_state = ST_RDY;
							end
						end
						sbm_pkg::OP_DUP: begin
							if (sp_w < W_ZERO || sp_w + W_ONE >= W_DEP) begin
								done   = 1'b1;
								n_halt = 1'b1;
								n_err  = sbm_pkg::ERR_STACK;
							end else begin
								n_state = ST_RDY;
							end
						end
						sbm_pkg::OP_INCSP: begin
							done = 1'b1;
							if (inc_w < W_NEG1 || inc_w >= W_DEP) begin
								n_halt = 1'b1;
								n_err  = sbm_pkg::ERR_STACK;
							end else begin
								n_sp = SW'(inc_w);
								n_pc = pc_q + 16'd2;
							end
						end
						sbm_pkg::OP_GOTO: begin
							done = 1'b1;
							n_pc = a_q[15:0];
						end
						sbm_pkg::OP_CALL: begin
							if (a_w < W_ZERO || a_w > sp_w + W_ONE || sp_w + W_TWO >= W_DEP) begin
								done   = 1'b1;
								n_halt = 1'b1;
								n_err  = sbm_pkg::ERR_STACK;
							end else begin
								n_num   = SW'(a_q);
								n_cnt   = '0;
								n_state = ST_CALL_RD;
							end
						end
						sbm_pkg::OP_TCALL: begin
							if (a_w < W_ZERO || b_w < W_ZERO || a_w + b_w > sp_w + W_ONE) begin
								done   = 1'b1;
								n_halt = 1'b1;
								n_err  = sbm_pkg::ERR_STACK;
							end else begin
								n_num   = SW'(a_q);
								n_dis   = SW'(b_q);
								n_cnt   = '0;
								n_state = ST_TC_RD;
							end
						end
						sbm_pkg::OP_RET: begin
							if (sp_w < W_ZERO || a_w < W_ZERO || sp_w - a_w < W_TWO) begin
								done   = 1'b1;
								n_halt = 1'b1;
								n_err  = sbm_pkg::ERR_STACK;
							end else begin
								n_t     = AW'(sp_w - a_w);
								n_state = ST_RDY;
							end
						end
						sbm_pkg::OP_LDARGS: begin
							if (sp_w + signed'(WW'(args_n)) >= W_DEP) begin
								done   = 1'b1;
								n_halt = 1'b1;
								n_err  = sbm_pkg::ERR_STACK;
							end else begin
								n_num   = SW'(args_n);
								n_cnt   = '0;
								n_state = ST_ARGS;
							end
						end
						sbm_pkg::OP_STOP: begin
							done   = 1'b1;
							n_halt = 1'b1;
						end
						default: begin
							done   = 1'b1;
							n_halt = 1'b1;
							n_err  = sbm_pkg::ERR_ILLEGAL;
						end
					endcase
				end
			end
			ST_RDY: begin
				n_y   = rdata_q;
				raddr = AW'(sp_q - SW'(1));
				n_state = ST_RDX;
				unique case (op_q) inside
					sbm_pkg::OP_NOT: begin
						we    = 1'b1;
						waddr = AW'(sp_q);
						wdata = {31'd0, rdata_q == 32'd0};
						n_pc  = pc_q + 16'd1;
						done  = 1'b1;
					end
					sbm_pkg::OP_DUP: begin
						we    = 1'b1;
						waddr = AW'(sp_q + SW'(1));
						wdata = rdata_q;
						n_sp  = sp_q + SW'(1);
						n_pc  = pc_q + 16'd1;
						done  = 1'b1;
					end
					sbm_pkg::OP_IFZERO, sbm_pkg::OP_IFNZRO: begin
						n_sp = sp_q - SW'(1);
						if ((op_q == sbm_pkg::OP_IFZERO) == (rdata_q == 32'd0)) begin
							n_pc = a_q[15:0];
						end else begin
							n_pc = pc_q + 16'd2;
						end
						done = 1'b1;
					end
					sbm_pkg::OP_PRINTI, sbm_pkg::OP_PRINTC: begin
						pv   = 1'b1;
						pk   = (op_q == sbm_pkg::OP_PRINTC);
						pval = rdata_q;
						n_pc = pc_q + 16'd1;
						done = 1'b1;
					end
					sbm_pkg::OP_LDI: begin
						if (rd_w < W_ZERO || rd_w > sp_w) begin
							done   = 1'b1;
							n_halt = 1'b1;
							n_err  = sbm_pkg::ERR_ADDR;
						end else begin
							raddr   = AW'(rdata_q);
							n_state = ST_LDI;
						end
					end
					sbm_pkg::OP_RET: begin
						n_x     = rdata_q;
						raddr   = t_q - AW'(1);
						n_state = ST_RET1;
					end
					default: begin
						n_state = ST_RDX;
					end
				endcase
				if (done) begin
					n_state = ST_IDLE;
				end
			end
			ST_RDX: begin
				unique case (op_q) inside
					sbm_pkg::OP_DIV, sbm_pkg::OP_MOD: begin
						if (y_q == 32'd0) begin
							done   = 1'b1;
							n_halt = 1'b1;
							n_err  = sbm_pkg::ERR_DIV0;
						end else begin
							div_req.start = 1'b1;
							n_state       = ST_DIV;
						end
					end
					sbm_pkg::OP_SWAP: begin
						we      = 1'b1;
						waddr   = AW'(sp_q);
						wdata   = rdata_q;
						n_state = ST_SWAP2;
					end
					sbm_pkg::OP_STI: begin
						if (x_w < W_ZERO || x_w > sp_w) begin
							done   = 1'b1;
							n_halt = 1'b1;
							n_err  = sbm_pkg::ERR_ADDR;
						end else begin
							we      = 1'b1;
							waddr   = AW'(rdata_q);
							wdata   = y_q;
							n_state = ST_STI2;
						end
					end
					default: begin
						we    = 1'b1;
						waddr = AW'(sp_q - SW'(1));
						wdata = alu;
						n_sp  = sp_q - SW'(1);
						n_pc  = pc_q + 16'd1;
						done  = 1'b1;
					end
				endcase
			end
			ST_DIV: begin
				if (div_rsp.done) begin
					we    = 1'b1;
					waddr = AW'(sp_q - SW'(1));
					wdata = (op_q == sbm_pkg::OP_DIV) ? div_rsp.quo : div_rsp.rem;
					n_sp  = sp_q - SW'(1);
					n_pc  = pc_q + 16'd1;
					done  = 1'b1;
				end
			end
			ST_SWAP2: begin
				we    = 1'b1;
				waddr = AW'(sp_q - SW'(1));
				wdata = y_q;
				n_pc  = pc_q + 16'd1;
				done  = 1'b1;
			end
			ST_STI2: begin
				we    = 1'b1;
				waddr = AW'(sp_q - SW'(1));
				wdata = y_q;
				n_sp  = sp_q - SW'(1);
				n_pc  = pc_q + 16'd1;
				done  = 1'b1;
			end
			ST_LDI: begin
				we    = 1'b1;
				waddr = AW'(sp_q);
				wdata = rdata_q;
				n_pc  = pc_q + 16'd1;
				done  = 1'b1;
			end
			ST_RET1: begin
				n_fb    = rdata_q;
				raddr   = t_q - AW'(2);
				n_state = ST_RET2;
			end
			ST_RET2: begin
				n_pc  = rdata_q[15:0];
				n_sp  = signed'({1'b0, t_q - AW'(2)});
				we    = 1'b1;
				waddr = t_q - AW'(2);
				wdata = x_q;
				done  = 1'b1;
			end
			ST_CALL_RD: begin
				if (cnt_q < num_q) begin
					raddr   = AW'(sp_q - cnt_q);
					n_state = ST_CALL_WR;
				end else begin
					n_state = ST_CALL_RA;
				end
			end
			ST_CALL_WR: begin
				we      = 1'b1;
				waddr   = AW'(sp_q - cnt_q + SW'(2));
				wdata   = rdata_q;
				n_cnt   = cnt_q + SW'(1);
				n_state = ST_CALL_RD;
			end
			ST_CALL_RA: begin
				we      = 1'b1;
				waddr   = AW'(sp_q - num_q + SW'(1));
				wdata   = {16'd0, pc_q + 16'd3};
				n_state = ST_CALL_FB;
			end
			ST_CALL_FB: begin
				we    = 1'b1;
				waddr = AW'(sp_q - num_q + SW'(2));
				wdata = fb_q;
				n_sp  = sp_q + SW'(2);
				n_fb  = 32'(sp_w + WW'(3) - num_w);
				n_pc  = b_q[15:0];
				done  = 1'b1;
			end
			ST_TC_RD: begin
				if (cnt_q < num_q) begin
					raddr   = AW'(sp_q - num_q + SW'(1) + cnt_q);
					n_state = ST_TC_WR;
				end else begin
					n_sp = sp_q - dis_q;
					n_pc = c_q[15:0];
					done = 1'b1;
				end
			end
			ST_TC_WR: begin
				we      = 1'b1;
				waddr   = AW'(sp_q - num_q + SW'(1) + cnt_q - dis_q);
				wdata   = rdata_q;
				n_cnt   = cnt_q + SW'(1);
				n_state = ST_TC_RD;
			end
			ST_ARGS: begin
				if (cnt_q < num_q) begin
					we    = 1'b1;
					waddr = AW'(sp_q + SW'(1) + cnt_q);
					wdata = arg_val[cnt_q[sbm_pkg::ARG_IDX_W-1:0]];
					n_cnt = cnt_q + SW'(1);
				end else begin
					n_sp = sp_q + num_q;
					n_pc = pc_q + 16'd1;
					done = 1'b1;
				end
			end
			default: begin
				n_state = ST_IDLE;
			end
		endcase
		if (done) begin
			n_state = ST_IDLE;
		end
	end

	assign res_push = done;

	always_comb begin
		res_data.next_pc     = n_pc;
		res_data.print_valid = pv;
		res_data.print_kind  = pk;
		res_data.print_value = pval;
		res_data.halted      = n_halt;
		res_data.error_code  = n_err;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sp_q    <= '1;
			fb_q    <= sbm_pkg::FB_RESET;
			pc_q    <= '0;
			halt_q  <= 1'b0;
			err_q   <= sbm_pkg::ERR_NONE;
		end else begin
			state_q <= n_state;
			sp_q    <= n_sp;
			fb_q    <= n_fb;
			pc_q    <= n_pc;
			halt_q  <= n_halt;
			err_q   <= n_err;
		end
	end

	always_ff @(posedge clk) begin
		if (item_pop) begin
			op_q  <= item.instr.opcode;
			ill_q <= item.illegal;
			a_q   <= item.instr.operand_a;
			b_q   <= item.instr.operand_b;
			c_q   <= item.instr.operand_c;
		end
		x_q   <= n_x;
		y_q   <= n_y;
		cnt_q <= n_cnt;
		num_q <= n_num;
		dis_q <= n_dis;
		t_q   <= n_t;
	end

	always_ff @(posedge clk) begin
		if (we) begin
			stack_mem[waddr] <= wdata;
		end
		rdata_q <= stack_mem[raddr];
	end

endmodule

// ===== sv/stack_bytecode_machine.sv =====
// Each instruction passes from the front queue through the back end to its result; DIV and MOD
// run on the radix-2 divider, and CALL and TCALL move each word by reading it from the stack
// into a register and then writing it back, while LDARGS writes each argument word directly.
// The back end takes one instruction at a time; the input and result queues hold two each.
// Reset is asynchronous and active low: the stack is empty, the base pointer is -999, the
// program counter is zero and the core is running; stack memory contents are not cleared.
module stack_bytecode_machine (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	output logic                            full,
	input  sbm_pkg::instr_t                 instr,
	output logic                            empty,
	input  logic                            pop,
	output sbm_pkg::result_t                result,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [sbm_pkg::PADDR_W-1:0]     paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready
);

	logic              deq_valid;
	logic              deq;
	sbm_pkg::dec_t     deq_item;
	logic              res_push;
	sbm_pkg::result_t  res_data;
	sbm_pkg::div_req_t div_req;
	sbm_pkg::div_rsp_t div_rsp;

	logic [2:0]        arg_count_q;
	logic [31:0]       arg_q [sbm_pkg::MAX_ARGS];
	logic              cfg_wr;

	sbm_pkg::result_t  oq_q [2];
	logic              oq_wr_q;
	logic              oq_rd_q;
	logic [1:0]        oq_cnt_q;
	logic              oq_pop;

	sbm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.instr     (instr),
		.deq_valid (deq_valid),
		.deq       (deq),
		.deq_item  (deq_item)
	);

	sbm_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (deq_valid),
		.item       (deq_item),
		.item_pop   (deq),
		.room       (oq_cnt_q != 2'd2),
		.arg_count  (arg_count_q),
		.arg_val    (arg_q),
		.res_push   (res_push),
		.res_data   (res_data),
		.div_req    (div_req),
		.div_rsp    (div_rsp)
	);

	sbm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arg_count_q <= 3'd0;
			for (int i = 0; i < sbm_pkg::MAX_ARGS; i++) begin
				arg_q[i] <= 32'd0;
			end
		end else if (cfg_wr) begin
			case (paddr[4:2])
				sbm_pkg::REG_ARG_COUNT: arg_count_q <= pwdata[2:0];
				sbm_pkg::REG_ARG_0:     arg_q[0] <= pwdata;
				sbm_pkg::REG_ARG_1:     arg_q[1] <= pwdata;
				sbm_pkg::REG_ARG_2:     arg_q[2] <= pwdata;
				sbm_pkg::REG_ARG_3:     arg_q[3] <= pwdata;
				default:                arg_count_q <= arg_count_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			sbm_pkg::REG_ARG_COUNT: prdata = {29'd0, arg_count_q};
			sbm_pkg::REG_ARG_0:     prdata = arg_q[0];
			sbm_pkg::REG_ARG_1:     prdata = arg_q[1];
			sbm_pkg::REG_ARG_2:     prdata = arg_q[2];
			sbm_pkg::REG_ARG_3:     prdata = arg_q[3];
			default:                prdata = 32'd0;
		endcase
	end

	assign empty  = (oq_cnt_q == 2'd0);
	assign result = oq_q[oq_rd_q];
	assign oq_pop = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_wr_q  <= 1'b0;
			oq_rd_q  <= 1'b0;
			oq_cnt_q <= 2'd0;
		end else begin
			if (res_push) begin
				oq_wr_q <= !oq_wr_q;
			end
			if (oq_pop) begin
				oq_rd_q <= !oq_rd_q;
			end
			oq_cnt_q <= oq_cnt_q + {1'b0, res_push} - {1'b0, oq_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (res_push) begin
			oq_q[oq_wr_q] <= res_data;
		end
	end

`ifndef SYNTH
	a_no_result_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> oq_cnt_q != 2'd2)
		else $error("Result transaction written into a full result queue.");

	a_error_halts: assert property (@(posedge clk) disable iff (!arst_n)
		(res_push && !res_data.halted) |-> res_data.error_code == sbm_pkg::ERR_NONE)
		else $error("Error code reported while the core is running.");

	a_print_running: assert property (@(posedge clk) disable iff (!arst_n)
		(res_push && res_data.print_valid) |-> !res_data.halted)
		else $error("Print transaction from a halted core.");
`endif

endmodule

// ===== verif/tb_stack_bytecode_machine.sv =====
`timescale 1ns / 100ps

module tb_stack_bytecode_machine;
	import sbm_pkg::*;

	localparam int ITEMS  = 1850;
	localparam int PHASES = 6;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                push = 1'b0;
	logic                full;
	instr_t              instr = '0;
	logic                empty;
	logic                pop = 1'b0;
	result_t             result;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [PADDR_W-1:0]  paddr = '0;
	logic [31:0]         pwdata = '0;
	logic [31:0]         prdata;
	logic                pready;

	stack_bytecode_machine DUT (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .instr(instr),
		.empty(empty), .pop(pop), .result(result), .psel(psel), .penable(penable),
		.pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #10 clk = ~clk;

	// Shadow machine state used to predict every result.
	logic [31:0] stk_mem [STACK_DEPTH];
	bit          stk_wr  [STACK_DEPTH];
	logic [31:0] mem_bk  [STACK_DEPTH];
	bit          wr_bk   [STACK_DEPTH];
	int          sp, sp_bk;
	logic [31:0] fb, fb_bk;
	logic [15:0] pc, pc_bk;
	bit          halt, halt_bk;
	logic [2:0]  err, err_bk;
	logic [2:0]  argc;
	logic [31:0] args [4];
	bit          stale_read;

	instr_t  pending [$];
	result_t expq [$];
	int      issued, checked, failures, prints, calls;
	int      send_gap, send_burst, recv_gap, recv_burst;
	bit      hold;
	string   halt_cause;

	function automatic int draw_gap(inout int burst);
		if (burst > 0) begin
			burst--;
			return 0;
		end
		if ($urandom_range(0, 19) == 0) begin
			burst = $urandom_range(8, 40);
			return 0;
		end
		return $urandom_range(0, 16);
	endfunction

	function automatic logic [31:0] peek(longint addr);
		if (!stk_wr[addr])
			stale_read = 1'b1;
		return stk_mem[addr];
	endfunction

	function automatic void poke(longint addr, logic [31:0] v);
		stk_mem[addr] = v;
		stk_wr[addr] = 1'b1;
	endfunction

	function automatic result_t execute(instr_t ins);
		result_t     r;
		logic [31:0] x, y, npc;
		longint      s, a, b, c, t, n, q;
		logic [2:0]  e;
		r = '0;
		if (halt) begin
			r.next_pc = pc;
			r.halted = 1'b1;
			r.error_code = err;
			return r;
		end
		s = sp;
		a = $signed(ins.operand_a);
		b = $signed(ins.operand_b);
		c = $signed(ins.operand_c);
		npc = {16'd0, pc};
		e = ERR_NONE;
		case (ins.opcode)
			OP_CSTI: begin
				if (s + 1 >= STACK_DEPTH) e = ERR_STACK;
				else begin
					poke(s + 1, ins.operand_a); s++; npc += 2;
				end
			end
			OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_EQ, OP_LT: begin
				if (s < 1) e = ERR_STACK;
				else begin
					x = peek(s - 1);
					y = peek(s);
					if ((ins.opcode == OP_DIV || ins.opcode == OP_MOD) && y == 0) e = ERR_DIV0;
					else begin
						case (ins.opcode)
							OP_ADD: x = x + y;
							OP_SUB: x = x - y;
							OP_MUL: x = x * y;
							OP_DIV: begin
								q = longint'($signed(x)) / longint'($signed(y));
								x = q[31:0];
							end
							OP_MOD: begin
								q = longint'($signed(x)) % longint'($signed(y));
								x = q[31:0];
							end
							OP_EQ:  x = (x == y) ? 32'd1 : 32'd0;
							default: x = ($signed(x) < $signed(y)) ? 32'd1 : 32'd0;
						endcase
						poke(s - 1, x); s--; npc += 1;
					end
				end
			end
			OP_NOT: begin
				if (s < 0) e = ERR_STACK;
				else begin
					poke(s, (peek(s) == 0) ? 32'd1 : 32'd0); npc += 1;
				end
			end
			OP_DUP: begin
				if (s < 0 || s + 1 >= STACK_DEPTH) e = ERR_STACK;
				else begin
					poke(s + 1, peek(s)); s++; npc += 1;
				end
			end
			OP_SWAP: begin
				if (s < 1) e = ERR_STACK;
				else begin
					x = peek(s); poke(s, peek(s - 1)); poke(s - 1, x); npc += 1;
				end
			end
			OP_LDI: begin
				if (s < 0) e = ERR_STACK;
				else begin
					t = $signed(peek(s));
					if (t < 0 || t > s) e = ERR_ADDR;
					else begin
						poke(s, peek(t)); npc += 1;
					end
				end
			end
			OP_STI: begin
				if (s < 1) e = ERR_STACK;
				else begin
					t = $signed(peek(s - 1));
					if (t < 0 || t > s) e = ERR_ADDR;
					else begin
						y = peek(s); poke(t, y); poke(s - 1, y); s--; npc += 1;
					end
				end
			end
			OP_GETBP, OP_GETSP: begin
				if (s + 1 >= STACK_DEPTH) e = ERR_STACK;
				else begin
					poke(s + 1, (ins.opcode == OP_GETBP) ? fb : s[31:0]); s++; npc += 1;
				end
			end
			OP_INCSP: begin
				t = s + a;
				if (t < -1 || t >= STACK_DEPTH) e = ERR_STACK;
				else begin
					s = t; npc += 2;
				end
			end
			OP_GOTO: npc = ins.operand_a;
			OP_IFZERO, OP_IFNZRO: begin
				if (s < 0) e = ERR_STACK;
				else begin
					x = peek(s); s--;
					if ((ins.opcode == OP_IFZERO) ? (x == 0) : (x != 0)) npc = ins.operand_a;
					else npc += 2;
				end
			end
			OP_CALL: begin
				n = a;
				if (n < 0 || n > s + 1 || s + 2 >= STACK_DEPTH) e = ERR_STACK;
				else begin
					for (longint i = 0; i < n; i++)
						poke(s - i + 2, peek(s - i));
					poke(s - n + 1, {16'd0, pc + 16'd3});
					poke(s - n + 2, fb);
					s += 2;
					q = s + 1 - n;
					fb = q[31:0];
					npc = ins.operand_b;
				end
			end
			OP_TCALL: begin
				if (a < 0 || b < 0 || a + b > s + 1) e = ERR_STACK;
				else begin
					for (longint i = a - 1; i >= 0; i--)
						poke(s - i - b, peek(s - i));
					s -= b;
					npc = ins.operand_c;
				end
			end
			OP_RET: begin
				if (s < 0 || a < 0 || s - a < 2) e = ERR_STACK;
				else begin
					x = peek(s);
					t = s - a;
					fb = peek(t - 1);
					npc = peek(t - 2);
					s = t - 2;
					poke(s, x);
				end
			end
			OP_PRINTI, OP_PRINTC: begin
				if (s < 0) e = ERR_STACK;
				else begin
					r.print_valid = 1'b1;
					r.print_kind = (ins.opcode == OP_PRINTC);
					r.print_value = peek(s);
					npc += 1;
				end
			end
			OP_LDARGS: begin
				n = (argc > MAX_ARGS) ? MAX_ARGS : argc;
				if (s + n >= STACK_DEPTH) e = ERR_STACK;
				else begin
					for (int i = 0; i < n; i++) begin
						s++; poke(s, args[i]);
					end
					npc += 1;
				end
			end
			OP_STOP: halt = 1'b1;
			default: e = ERR_ILLEGAL;
		endcase
		if (e != ERR_NONE) begin
			halt = 1'b1;
			err = e;
			r = '0;
		end else begin
			sp = s;
			pc = npc[15:0];
		end
		r.next_pc = pc;
		r.halted = halt;
		r.error_code = err;
		return r;
	endfunction

	task automatic offer(input instr_t ins, input bit may_halt, output bit taken);
		result_t r;
		mem_bk = stk_mem; wr_bk = stk_wr;
		sp_bk = sp; fb_bk = fb; pc_bk = pc; halt_bk = halt; err_bk = err;
		stale_read = 1'b0;
		r = execute(ins);
		if (stale_read || (r.halted && !may_halt)) begin
			stk_mem = mem_bk; stk_wr = wr_bk;
			sp = sp_bk; fb = fb_bk; pc = pc_bk; halt = halt_bk; err = err_bk;
			taken = 1'b0;
		end else begin
			pending.push_back(ins);
			expq.push_back(r);
			issued++;
			if (r.print_valid) prints++;
			if (ins.opcode == OP_CALL || ins.opcode == OP_TCALL) calls++;
			taken = 1'b1;
		end
	endtask

	function automatic instr_t mk(logic [7:0] op, logic [31:0] a);
		instr_t ins;
		ins.opcode = op;
		ins.operand_a = a;
		ins.operand_b = $urandom;
		ins.operand_c = $urandom;
		return ins;
	endfunction

	task automatic send(logic [7:0] op, logic [31:0] a);
		bit ok;
		offer(mk(op, a), 1'b0, ok);
	endtask

	task automatic random_item();
		instr_t     ins;
		logic [7:0] op;
		bit         ok;
		op = $urandom_range(0, 24);
		ins = mk(op, $urandom);
		if (sp > 400) begin
			send(OP_INCSP, -$urandom_range(1, 80));
			return;
		end
		case (op)
			OP_CSTI: if ($urandom_range(0, 7) == 0)
				ins.operand_a = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
			OP_INCSP: ins.operand_a = $urandom_range(0, 12) - 6;
			OP_CALL: begin
				ins.operand_a = ($urandom_range(0, 40) == 0) ? $urandom_range(0, sp + 1)
					: $urandom_range(0, 4);
			end
			OP_TCALL: begin
				ins.operand_a = $urandom_range(0, 4);
				ins.operand_b = $urandom_range(0, 4);
			end
			OP_RET: ins.operand_a = $urandom_range(0, 4);
			OP_LDI: send(OP_CSTI, $urandom_range(0, sp + 1));
			OP_STI: begin
				send(OP_CSTI, $urandom_range(0, sp + 1));
				send(OP_CSTI, $urandom);
			end
			OP_DIV, OP_MOD: if ($urandom_range(0, 1)) begin
				send(OP_CSTI, $urandom);
				send(OP_CSTI, $urandom_range(0, 3) == 0 ? 32'hFFFF_FFFF : $urandom);
			end
			OP_IFZERO, OP_IFNZRO: if ($urandom_range(0, 1))
				send(OP_CSTI, $urandom_range(0, 1));
			default: ;
		endcase
		offer(ins, 1'b0, ok);
	endtask

	task automatic apb_access(logic wr, logic [2:0] idx, logic [31:0] wdata);
		logic [31:0] got;
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= wr;
		paddr <= {idx, 2'b00}; pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		got = prdata;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		if (!wr && got !== wdata) begin
			$display("%0t: register %0d read back: expected %h, actual %h", $time, idx, wdata, got);
			failures++;
		end
	endtask

	task automatic set_reg(logic [2:0] idx, logic [31:0] v);
		apb_access(1'b1, idx, v);
		apb_access(1'b0, idx, v);
		if (idx == REG_ARG_COUNT) argc = v[2:0];
		else args[idx - 1] = v;
	endtask

	task automatic drain();
		while (pending.size() != 0 || expq.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push <= 1'b0;
			instr <= '0;
		end else begin
			hold = push && full;
			if (push && !full)
				send_gap = draw_gap(send_burst);
			if (!hold) begin
				if (send_gap > 0) begin
					send_gap--;
					push <= 1'b0;
				end else if (pending.size() != 0) begin
					instr <= pending.pop_front();
					push <= 1'b1;
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				if (expq.size() == 0) begin
					$display("%0t: unexpected result %p", $time, result);
					failures++;
				end else begin
					result_t exp_r;
					exp_r = expq.pop_front();
					checked++;
					if (result !== exp_r) begin
						$display("%0t: result mismatch: expected %p, actual %p", $time, exp_r, result);
						failures++;
					end
				end
				recv_gap = draw_gap(recv_burst);
			end
			if (recv_gap > 0) begin
				recv_gap--;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	initial begin
		#40_000_000;
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		int      old_sp;
		int      kind;
		bit      ok;
		instr_t  ins;
		logic [31:0] counts [PHASES];
		sp = -1; fb = FB_RESET; pc = '0; halt = 1'b0; err = ERR_NONE;
		argc = '0;
		for (int i = 0; i < 4; i++) args[i] = '0;
		for (int i = 0; i < STACK_DEPTH; i++) begin
			stk_mem[i] = '0; stk_wr[i] = 1'b0;
		end
		counts = '{32'd0, 32'd4, 32'd2, 32'd1, 32'd3, 32'd4};
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int ph = 0; ph < PHASES; ph++) begin
			set_reg(REG_ARG_COUNT, ph == PHASES - 1 ? $urandom_range(0, 4) : counts[ph]);
			set_reg(REG_ARG_0, ph == 0 ? 32'h7FFF_FFFF : ph == 1 ? 32'h8000_0000 : $urandom);
			set_reg(REG_ARG_1, ph == 0 ? 32'h8000_0000 : ph == 1 ? 32'h7FFF_FFFF : $urandom);
			set_reg(REG_ARG_2, ph == 0 ? 32'd0 : ph == 1 ? 32'hFFFF_FFFF : $urandom);
			set_reg(REG_ARG_3, ph == 0 ? 32'hFFFF_FFFF : ph == 1 ? 32'd0 : $urandom);
			if (ph == 0) begin
				send(OP_CSTI, 32'h7FFF_FFFF);
				send(OP_CSTI, 32'h8000_0000);
				send(OP_ADD, 0);
				send(OP_CSTI, 32'h8000_0000);
				send(OP_CSTI, 32'hFFFF_FFFF);
				send(OP_DIV, 0);
				send(OP_CSTI, 32'h8000_0000);
				send(OP_CSTI, 32'hFFFF_FFFF);
				send(OP_MOD, 0);
				send(OP_SUB, 0);
				send(OP_MUL, 0);
				send(OP_LT, 0);
				send(OP_NOT, 0);
				send(OP_DUP, 0);
				send(OP_EQ, 0);
				send(OP_GETBP, 0);
				send(OP_GETSP, 0);
				send(OP_SWAP, 0);
				send(OP_PRINTI, 0);
				send(OP_PRINTC, 0);
				send(OP_LDARGS, 0);
				old_sp = sp;
				send(OP_INCSP, STACK_DEPTH - 1 - sp);
				send(OP_INCSP, old_sp - sp);
				ins = mk(OP_CALL, 2);
				ins.operand_b = 32'hFFFF_FFFF;
				offer(ins, 1'b0, ok);
				ins = mk(OP_TCALL, 1);
				ins.operand_b = 1;
				ins.operand_c = 32'h0001_0005;
				offer(ins, 1'b0, ok);
				send(OP_RET, 0);
				send(OP_IFZERO, 32'hFFFF_FFFF);
				send(OP_GOTO, 32'h8000_0000);
				send(OP_IFNZRO, 32'h0000_1234);
			end
			while (issued < (ph + 1) * ITEMS / PHASES)
				random_item();
			drain();
		end

		if (sp > STACK_DEPTH - 4)
			send(OP_INCSP, -8);
		kind = $urandom_range(0, 4);
		case (kind)
			0: begin halt_cause = "stop"; ins = mk(OP_STOP, $urandom); end
			1: begin halt_cause = "illegal opcode"; ins = mk($urandom_range(26, 255), $urandom); end
			2: begin halt_cause = "stack underflow"; ins = mk(OP_INCSP, -(sp + 2)); end
			3: begin
				halt_cause = "bad indirect address";
				send(OP_CSTI, 32'hFFFF_FFFF);
				ins = mk(OP_LDI, $urandom);
			end
			default: begin
				halt_cause = "division by zero";
				send(OP_CSTI, $urandom);
				send(OP_CSTI, 32'd0);
				ins = mk(OP_DIV, $urandom);
			end
		endcase
		offer(ins, 1'b1, ok);
		for (int i = 0; i < 24; i++) begin
			ins.opcode = $urandom;
			ins.operand_a = $urandom;
			ins.operand_b = $urandom;
			ins.operand_c = $urandom;
			offer(ins, 1'b1, ok);
		end
		drain();
		repeat (20) @(posedge clk);

		$display("Checked %0d instruction transactions over %0d register settings (%0d prints, %0d calls).",
			checked, PHASES, prints, calls);
		$display("The run closed on a halt by %s, with inputs ignored afterwards.", halt_cause);
		if (failures == 0 && expq.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
